@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define GCM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define GCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/gcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Gradient color mapper package
// Shared types, opcodes and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gcm_pkg;

    localparam int CH_W     = 8;
    localparam int CNT_W    = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    localparam logic [CNT_W-1:0] STOP_COUNT_RESET = 5'd2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Red sits in the lowest byte.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgba_t;

    typedef struct packed {
        rgba_t           lo;
        rgba_t           hi;
        logic [CH_W-1:0] frac;
    } mix_req_t;

    // Exact floor(x / 255) for x up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

@@ sv/gcm_mix.sv @@
// ----------------------------------------------------------------------------
// Gradient color mixer
// Blends two RGBA stops per channel with weights (255 - frac) and frac.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_mix (
    input  gcm_pkg::mix_req_t req,
    output gcm_pkg::rgba_t    color
);
    import gcm_pkg::*;

    logic [3:0][CH_W-1:0] lo_ch;
    logic [3:0][CH_W-1:0] hi_ch;
    logic [3:0][CH_W-1:0] mix_ch;
    logic [3:0][15:0]     prod_lo;
    logic [3:0][15:0]     prod_hi;
    logic [CH_W-1:0]      inv_frac;

    assign lo_ch    = req.lo;
    assign hi_ch    = req.hi;
    assign inv_frac = 8'd255 - req.frac;

    // The weighted sum never exceeds 255 * 255, so 16 bits hold it exactly.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod_lo[i] = 16'(lo_ch[i]) * 16'(inv_frac);
            prod_hi[i] = 16'(hi_ch[i]) * 16'(req.frac);
            mix_ch[i]  = div255(prod_lo[i] + prod_hi[i]);
        end
    end

    assign color = mix_ch;

endmodule

`default_nettype wire

@@ sv/gradient_color_mapper_unit.sv @@
// Lookup: on acceptance the stop memory is read into the read registers, and the
// color is blended and loaded into the output register when it is empty or m_tready is high.
// A lookup holds off further input until its color is loaded; an append leaves the input ready for the next item.
// Reset clears the fill pointer, the state and output valid, and sets stop_count to 2;
// store entries at or above the fill pointer read as zero, so no clearing pass is run.
// ----------------------------------------------------------------------------
// Gradient color mapper unit
// Maps an 8-bit intensity to RGBA by linear interpolation between stored stops.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_color_mapper_unit #(
    parameter int MAX_STOPS = 16
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // intensity[7:0], stop_red[15:8], stop_green[23:16], stop_blue[31:24], stop_alpha[39:32]
    input  wire  [gcm_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode[0]
    input  wire  [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [gcm_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [gcm_pkg::CNT_W-1:0]      cfg_data
);
    import gcm_pkg::*;

    localparam int AW   = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int FP_W = $clog2(MAX_STOPS + 1);
    localparam logic [8:0] MAX9 = 9'(MAX_STOPS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_MIX  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [FP_W-1:0]   fill_ptr_reg, fill_ptr_next;
    logic [CNT_W-1:0]  stop_count_reg, stop_count_next;
    logic              m_valid_reg, m_valid_next;

    rgba_t             stop_mem [MAX_STOPS];
    rgba_t             rd_lo_reg, rd_hi_reg;
    logic              lo_ok_reg, hi_ok_reg;
    logic [CH_W-1:0]   frac_reg;
    rgba_t             m_data_reg;

    logic              s_beat, op_append, wr_en, rd_en, out_load;
    logic [8:0]        cnt9, n9, fill9, low9, high9;
    logic [CNT_W-1:0]  n_eff, nm1, low5, high5;
    logic [12:0]       pos, frac13;
    logic [CH_W-1:0]   frac;
    logic [AW-1:0]     lo_idx, hi_idx, wr_idx;
    mix_req_t          mix_req;
    rgba_t             mix_color;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_beat    = s_tvalid && s_tready;
    assign op_append = (s_tuser[0] == OP_APPEND);

    // Effective stop count, saturated to 1..MAX_STOPS.
    always_comb begin
        cnt9 = 9'(stop_count_reg);
        if (cnt9 == 9'd0) begin
            n9 = 9'd1;
        end else if (cnt9 > MAX9) begin
            n9 = MAX9;
        end else begin
            n9 = cnt9;
        end
    end
    assign n_eff = CNT_W'(n9);
    assign nm1   = n_eff - 5'd1;
    assign fill9 = 9'(fill_ptr_reg);

    // Stop segment and fraction: pos stays below 255 * 31, so the quotient fits five bits.
    assign pos    = 13'(s_tdata[7:0]) * 13'(nm1);
    assign low5   = CNT_W'(div255(16'(pos)));
    assign frac13 = pos - {low5, 8'b0} + 13'(low5);
    assign frac   = frac13[CH_W-1:0];
    assign high5  = low5 + CNT_W'(frac != 8'd0);
    // Both indexes stay below the effective count, so the narrowing is safe.
    assign low9   = 9'(low5);
    assign high9  = 9'(high5);
    assign lo_idx = low9[AW-1:0];
    assign hi_idx = high9[AW-1:0];
    assign wr_idx = fill_ptr_reg[AW-1:0];

    assign wr_en = s_beat && op_append && (fill9 < n9);
    assign rd_en = s_beat && !op_append;

    // Appends and lookups are never accepted in the same cycle, so reads and
    // writes to the store cannot collide.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stop_mem[wr_idx] <= s_tdata[S_DATA_W-1:CH_W];
        end
        if (rd_en) begin
            rd_lo_reg <= stop_mem[lo_idx];
            rd_hi_reg <= stop_mem[hi_idx];
            lo_ok_reg <= (low9 < fill9);
            hi_ok_reg <= (high9 < fill9);
            frac_reg  <= frac;
        end
    end

    // Entries past the fill pointer were never written since reset and read as zero.
    always_comb begin
        mix_req.lo   = lo_ok_reg ? rd_lo_reg : '0;
        mix_req.hi   = hi_ok_reg ? rd_hi_reg : '0;
        mix_req.frac = frac_reg;
    end

    gcm_mix u_mix (
        .req   (mix_req),
        .color (mix_color)
    );

    assign out_load = (state_reg == S_MIX) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        fill_ptr_next   = fill_ptr_reg;
        stop_count_next = stop_count_reg;
        m_valid_next    = m_valid_reg;

        if (cfg_valid) begin
            stop_count_next = cfg_data;
        end
        if (wr_en) begin
            fill_ptr_next = fill_ptr_reg + FP_W'(1);
        end
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (rd_en) begin
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fill_ptr_reg   <= '0;
            stop_count_reg <= STOP_COUNT_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_ptr_reg   <= fill_ptr_next;
            stop_count_reg <= stop_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= mix_color;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ sv/gcm_checker.sv @@
// ----------------------------------------------------------------------------
// Gradient color mapper checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gcm_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [0:0]                      s_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [gcm_pkg::M_DATA_W-1:0]    m_tdata
);
    import gcm_pkg::*;

    logic lookup_beat, append_beat;

    assign lookup_beat = s_tvalid && s_tready && (s_tuser[0] == OP_LOOKUP);
    assign append_beat = s_tvalid && s_tready && (s_tuser[0] == OP_APPEND);

    `GCM_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "m_tvalid high after reset")
    `GCM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result beat changed")
    `GCM_ASSERT(a_lookup_result, aclk, aresetn, lookup_beat |=> ##1 m_tvalid, "lookup gave no result beat in time")
    `GCM_ASSERT(a_lookup_busy, aclk, aresetn, lookup_beat |=> !s_tready, "input accepted while a lookup is mixing")
    `GCM_ASSERT(a_append_silent, aclk, aresetn, append_beat && !m_tvalid |=> !m_tvalid, "append produced a result beat")

endmodule

bind gradient_color_mapper_unit gcm_checker u_gcm_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Gradient color mapper unit testbench
// Streams color stop appends and intensity lookups into the mapper under
// several stop counts and idle patterns. Each lookup's RGBA color is predicted
// from a local copy of the stop store, then compared channel by channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import gcm_pkg::*;

    localparam int STOP_SLOTS  = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 155;

    class color_scoreboard;
        rgba_t            stops[STOP_SLOTS];
        int unsigned      fill_level;
        logic [CNT_W-1:0] stop_count;
        rgba_t            colors_due[$];
        int unsigned      errors;

        function new();
            foreach (stops[i]) stops[i] = '0;
            fill_level = 0;
            stop_count = STOP_COUNT_RESET;
            errors     = 0;
        endfunction

        function void set_count(input logic [CNT_W-1:0] value);
            stop_count = value;
        endfunction

        function int unsigned pending();
            return colors_due.size();
        endfunction

        // Zero stops behave as one, anything past the store size as a full store.
        function int unsigned stop_span();
            int unsigned n;
            n = stop_count;
            if (n < 1) n = 1;
            if (n > STOP_SLOTS) n = STOP_SLOTS;
            return n;
        endfunction

        function logic [CH_W-1:0] blend(input logic [CH_W-1:0] lo_ch,
                                        input logic [CH_W-1:0] hi_ch,
                                        input int unsigned frac);
            int unsigned mix;
            mix = int'(lo_ch) * (255 - frac) + int'(hi_ch) * frac;
            return CH_W'(mix / 255);
        endfunction

        function void note_input(input logic op, input logic [S_DATA_W-1:0] data);
            int unsigned n;
            int unsigned pos;
            int unsigned lo_idx;
            int unsigned hi_idx;
            int unsigned frac;
            rgba_t       color;
            n = stop_span();
            if (op == OP_APPEND) begin
                // Appends beyond the current span are dropped silently.
                if (fill_level < n) begin
                    stops[fill_level] = rgba_t'(data[S_DATA_W-1:CH_W]);
                    fill_level++;
                end
            end else begin
                pos    = int'(data[CH_W-1:0]) * (n - 1);
                lo_idx = pos / 255;
                frac   = pos % 255;
                hi_idx = (frac > 0) ? lo_idx + 1 : lo_idx;
                color.red   = blend(stops[lo_idx].red,   stops[hi_idx].red,   frac);
                color.green = blend(stops[lo_idx].green, stops[hi_idx].green, frac);
                color.blue  = blend(stops[lo_idx].blue,  stops[hi_idx].blue,  frac);
                color.alpha = blend(stops[lo_idx].alpha, stops[hi_idx].alpha, frac);
                colors_due.push_back(color);
            end
        endfunction

        function void check_result(input logic [M_DATA_W-1:0] data);
            rgba_t got;
            rgba_t want;
            got = rgba_t'(data);
            if (colors_due.size() == 0) begin
                $error("unexpected color beat %h", data);
                errors++;
                return;
            end
            want = colors_due.pop_front();
            if (got.red !== want.red) begin
                $error("out_red: expected %0d, got %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("out_green: expected %0d, got %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("out_blue: expected %0d, got %0d", want.blue, got.blue);
                errors++;
            end
            if (got.alpha !== want.alpha) begin
                $error("out_alpha: expected %0d, got %0d", want.alpha, got.alpha);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;

    int unsigned           send_idle_pct = 14;
    int unsigned           recv_idle_pct = 73;
    int unsigned           quiet_cycles  = 0;
    color_scoreboard       sb;

    gradient_color_mapper_unit #(
        .MAX_STOPS (STOP_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Every handshake is observed here, so prediction follows acceptance order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.set_count(cfg_data);
            if (s_tvalid && s_tready) sb.note_input(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
                (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Called and returning just after a falling edge; tvalid stays high after the beat.
    task automatic push_item(input logic op, input logic [S_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Lets every lookup come back, then waits out an append still in flight.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic lookup(input logic [CH_W-1:0] intensity);
        push_item(OP_LOOKUP, {$urandom, intensity});
    endtask

    task automatic run_random(input int n_items, input bit hold_midway);
        logic [CH_W-1:0] intensity;
        for (int i = 0; i < n_items; i++) begin
            if (hold_midway && i == n_items / 2) wait_drain();
            if ($urandom_range(99) < 30) begin
                push_item(OP_APPEND, {$urandom, CH_W'($urandom)});
            end else begin
                case ($urandom_range(9))
                    0: intensity = 8'd0;
                    1: intensity = 8'hFF;
                    2: intensity = 8'd1;
                    default: intensity = CH_W'($urandom);
                endcase
                lookup(intensity);
            end
        end
    endtask

    initial begin
        logic [CNT_W-1:0] phase_counts[6];
        phase_counts = '{5'd31, 5'd16, 5'd9, 5'd0, 5'd2, 5'd5};
        sb = new();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Two-stop gradient from reset: empty store, partial fill, then full store.
        lookup(8'd0);
        lookup(8'hFF);
        push_item(OP_APPEND, {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h5A});
        lookup(8'hFF);
        push_item(OP_APPEND, {8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5});
        push_item(OP_APPEND, {8'h12, 8'h34, 8'h56, 8'h78, 8'h00});
        lookup(8'd0);
        lookup(8'd1);
        lookup(8'd127);
        lookup(8'd128);
        lookup(8'd254);
        lookup(8'hFF);

        // One stop: every intensity lands on the first stop and appends are dropped.
        write_count(5'd1);
        lookup(8'd0);
        lookup(8'd200);
        push_item(OP_APPEND, {32'hFFFF_FFFF, 8'hFF});
        lookup(8'hFF);
        write_count(5'd0);
        lookup(8'd0);
        lookup(8'hFF);

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 14;
                recv_idle_pct = 73;
            end else if (p < 4) begin
                send_idle_pct = 73;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 5) phase_counts[p] = CNT_W'($urandom_range(1, STOP_SLOTS));
            write_count(phase_counts[p]);
            run_random(PHASE_ITEMS, p == 2);
        end

        wait_drain();
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
